// File: rtl/core/tsat_pkg.sv
// Shared types and constants for the three-sigma activity threshold core.
package tsat_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MEAN_W      = 16;
    localparam int VAR_W       = 24;
    localparam int THR_W       = 20;
    localparam int SD_W        = 16;   // floor(sqrt(var * 256)) < 2^16
    localparam int TERM_W      = 18;   // term < 3 * sd
    localparam int PROD_W      = 42;   // 3 * sd * var
    localparam int FRAC_W      = 8;
    localparam int SQRT_IN_W   = VAR_W + FRAC_W;
    localparam int SQRT_STEPS  = SQRT_IN_W / 2;
    localparam int ONE_Q8      = 256;
    localparam int MEAN_MAX    = 32767;
    localparam int MEAN_NEGMAX = 32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_item_t;

    typedef struct packed {
        logic signed [THR_W-1:0]  threshold;
        logic signed [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]         variance;
        logic                     too_few;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MEAN,
        ST_NQ,
        ST_SS,
        ST_NUM,
        ST_DEN,
        ST_VDIV,
        ST_SQRT,
        ST_TMUL,
        ST_TDIV,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/tsat_alu.sv
// Shared add/subtract unit with carry out (carry = no borrow on subtract).
module tsat_alu #(
    parameter int AW = 8
) (
    input  logic [AW-1:0] a,
    input  logic [AW-1:0] b,
    input  logic          sub,
    output logic [AW-1:0] sum,
    output logic          carry
);

    logic [AW:0] full;

    assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{AW{1'b0}}, sub};
    assign sum   = full[AW-1:0];
    assign carry = full[AW];

endmodule

// File: rtl/core/tsat_accum.sv
// Row accumulators: sample count, running sum and running sum of squares.
module tsat_accum #(
    parameter int MAX_SAMPLES = 256,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int SW = tsat_pkg::SAMPLE_W + $clog2(MAX_SAMPLES),
    localparam int QW = 2 * tsat_pkg::SAMPLE_W - 1 + $clog2(MAX_SAMPLES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 acc_en,
    input  logic                 clear,
    input  tsat_pkg::in_item_t   item,
    output logic [CW-1:0]        count,
    output logic signed [SW-1:0] sum,
    output logic [QW-1:0]        sqsum
);

    logic [CW-1:0]                         count_reg;
    logic signed [SW-1:0]                  sum_reg;
    logic [QW-1:0]                         sqsum_reg;
    logic signed [2*tsat_pkg::SAMPLE_W-1:0] square;
    logic                                  room;

    assign square = item.sample * item.sample;
    assign room   = count_reg < CW'(MAX_SAMPLES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
        end
        else if (clear)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
        end
        else if (acc_en && room)
        begin
            count_reg <= count_reg + CW'(1);
            sum_reg   <= sum_reg +
                         {{(SW - tsat_pkg::SAMPLE_W){item.sample[tsat_pkg::SAMPLE_W-1]}},
                          item.sample};
            sqsum_reg <= sqsum_reg + QW'($unsigned(square));
        end
    end

    assign count = count_reg;
    assign sum   = sum_reg;
    assign sqsum = sqsum_reg;

endmodule

// File: rtl/core/tsat_seq.sv
// Result sequencer: mean, variance, sqrt and threshold on one shared adder.
module tsat_seq #(
    parameter int MAX_SAMPLES = 256,
    localparam int CW  = $clog2(MAX_SAMPLES + 1),
    localparam int SW  = tsat_pkg::SAMPLE_W + $clog2(MAX_SAMPLES),
    localparam int QW  = 2 * tsat_pkg::SAMPLE_W - 1 + $clog2(MAX_SAMPLES),
    localparam int DW0 = (CW + QW > 2 * SW) ? CW + QW : 2 * SW,
    localparam int DW  = (DW0 > tsat_pkg::PROD_W) ? DW0 : tsat_pkg::PROD_W,
    localparam int STW = $clog2(DW)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    take,
    input  logic [CW-1:0]           count,
    input  logic signed [SW-1:0]    sum,
    input  logic [QW-1:0]           sqsum,
    output logic                    busy,
    output logic                    done,
    output logic                    clear,
    output tsat_pkg::out_item_t     result
);

    localparam int AW = DW + 1;

    tsat_pkg::state_t state_reg, state_next;
    logic [STW-1:0]   step_reg, step_next;
    logic [DW-1:0]    r_reg, r_next;
    logic [DW-1:0]    q_reg, q_next;
    logic [DW-1:0]    d_reg, d_next;
    logic [DW-1:0]    t_reg, t_next;
    logic signed [tsat_pkg::MEAN_W-1:0] mean_reg, mean_next;
    logic [tsat_pkg::VAR_W-1:0]         var_reg, var_next;
    logic signed [tsat_pkg::THR_W-1:0]  thr_reg, thr_next;
    logic                               few_reg, few_next;

    logic [AW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_carry;

    logic [DW-1:0] div_r, div_q, mul_r, sq_r, sq_t, shl1, shl2;
    logic          last_step;
    logic [SW-1:0] sabs, mag;
    logic [tsat_pkg::MEAN_W:0]          mag_c, neg_c;
    logic signed [tsat_pkg::MEAN_W-1:0] mean_c;
    logic [tsat_pkg::VAR_W-1:0]         var_c;
    logic [tsat_pkg::SD_W-1:0]          sd;
    logic [tsat_pkg::TERM_W-1:0]        sd3, term;
    logic [tsat_pkg::VAR_W:0]           tdiv_den;
    logic [CW-1:0]                      count_m1;

    tsat_alu #(.AW(AW)) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // operand select for the shared unit
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg) inside
            tsat_pkg::ST_MEAN, tsat_pkg::ST_VDIV, tsat_pkg::ST_TDIV:
            begin
                alu_a   = {r_reg, q_reg[DW-1]};
                alu_b   = {1'b0, d_reg};
                alu_sub = 1'b1;
            end
            tsat_pkg::ST_NQ, tsat_pkg::ST_SS, tsat_pkg::ST_DEN, tsat_pkg::ST_TMUL:
            begin
                alu_a = {r_reg, 1'b0};
                alu_b = q_reg[DW-1] ? {1'b0, d_reg} : '0;
            end
            tsat_pkg::ST_NUM:
            begin
                alu_a   = {1'b0, t_reg};
                alu_b   = {1'b0, r_reg};
                alu_sub = 1'b1;
            end
            tsat_pkg::ST_SQRT:
            begin
                alu_a   = {r_reg[DW-2:0], q_reg[DW-1:DW-2]};
                alu_b   = {t_reg[DW-2:0], 2'b01};
                alu_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // per-step results of each kind of iteration
    assign div_r     = alu_carry ? alu_sum[DW-1:0] : alu_a[DW-1:0];
    assign div_q     = {q_reg[DW-2:0], alu_carry};
    assign mul_r     = alu_sum[DW-1:0];
    assign sq_r      = alu_carry ? alu_sum[DW-1:0] : alu_a[DW-1:0];
    assign sq_t      = {t_reg[DW-2:0], alu_carry};
    assign shl1      = {q_reg[DW-2:0], 1'b0};
    assign shl2      = {q_reg[DW-3:0], 2'b00};
    assign last_step = (step_reg == '0);

    assign sabs     = sum[SW-1] ? SW'(-sum) : SW'(sum);
    assign count_m1 = count - CW'(1);

    // mean: magnitude quotient, sign restored, clamped to Q8.8
    assign mag    = div_q[SW-1:0];
    assign mag_c  = (mag > SW'(tsat_pkg::MEAN_NEGMAX)) ?
                    (tsat_pkg::MEAN_W+1)'(tsat_pkg::MEAN_NEGMAX) : mag[tsat_pkg::MEAN_W:0];
    assign neg_c  = -mag_c;
    assign mean_c = sum[SW-1] ? neg_c[tsat_pkg::MEAN_W-1:0] :
                    ((mag_c > (tsat_pkg::MEAN_W+1)'(tsat_pkg::MEAN_MAX)) ?
                     tsat_pkg::MEAN_W'(tsat_pkg::MEAN_MAX) : mag_c[tsat_pkg::MEAN_W-1:0]);

    assign var_c    = (|div_q[DW-1:tsat_pkg::VAR_W]) ? '1 : div_q[tsat_pkg::VAR_W-1:0];
    assign sd       = sq_t[tsat_pkg::SD_W-1:0];
    assign sd3      = {1'b0, sd, 1'b0} + {2'b00, sd};
    assign term     = div_q[tsat_pkg::TERM_W-1:0];
    assign tdiv_den = {1'b0, var_reg} + (tsat_pkg::VAR_W+1)'(tsat_pkg::ONE_Q8);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        t_next     = t_reg;
        mean_next  = mean_reg;
        var_next   = var_reg;
        thr_next   = thr_reg;
        few_next   = few_reg;
        clear      = 1'b0;
        if (!last_step)
        begin
            step_next = step_reg - STW'(1);
        end
        unique case (state_reg)
            tsat_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tsat_pkg::ST_LOAD;
                end
            end
            tsat_pkg::ST_LOAD:
            begin
                r_next     = '0;
                q_next     = DW'(sabs) << (DW - SW);
                d_next     = DW'(count);
                step_next  = STW'(SW - 1);
                few_next   = count < CW'(2);
                var_next   = '0;
                thr_next   = '0;
                state_next = tsat_pkg::ST_MEAN;
            end
            tsat_pkg::ST_MEAN:
            begin
                r_next = div_r;
                q_next = div_q;
                if (last_step)
                begin
                    mean_next = mean_c;
                    if (few_reg)
                    begin
                        state_next = tsat_pkg::ST_DONE;
                    end
                    else
                    begin
                        r_next     = '0;
                        d_next     = DW'(sqsum);
                        q_next     = DW'(count) << (DW - CW);
                        step_next  = STW'(CW - 1);
                        state_next = tsat_pkg::ST_NQ;
                    end
                end
            end
            tsat_pkg::ST_NQ:
            begin
                r_next = mul_r;
                q_next = shl1;
                if (last_step)
                begin
                    t_next     = mul_r;
                    r_next     = '0;
                    d_next     = DW'(sabs);
                    q_next     = DW'(sabs) << (DW - SW);
                    step_next  = STW'(SW - 1);
                    state_next = tsat_pkg::ST_SS;
                end
            end
            tsat_pkg::ST_SS:
            begin
                r_next = mul_r;
                q_next = shl1;
                if (last_step)
                begin
                    state_next = tsat_pkg::ST_NUM;
                end
            end
            tsat_pkg::ST_NUM:
            begin
                // numerator n*Q - S*S is never negative
                t_next     = alu_sum[DW-1:0];
                r_next     = '0;
                d_next     = DW'(count_m1);
                q_next     = DW'(count) << (DW - CW);
                step_next  = STW'(CW - 1);
                state_next = tsat_pkg::ST_DEN;
            end
            tsat_pkg::ST_DEN:
            begin
                r_next = mul_r;
                q_next = shl1;
                if (last_step)
                begin
                    d_next     = mul_r << tsat_pkg::FRAC_W;
                    q_next     = t_reg;
                    r_next     = '0;
                    step_next  = STW'(DW - 1);
                    state_next = tsat_pkg::ST_VDIV;
                end
            end
            tsat_pkg::ST_VDIV:
            begin
                r_next = div_r;
                q_next = div_q;
                if (last_step)
                begin
                    var_next   = var_c;
                    q_next     = DW'({var_c, {tsat_pkg::FRAC_W{1'b0}}})
                                 << (DW - tsat_pkg::SQRT_IN_W);
                    r_next     = '0;
                    t_next     = '0;
                    step_next  = STW'(tsat_pkg::SQRT_STEPS - 1);
                    state_next = tsat_pkg::ST_SQRT;
                end
            end
            tsat_pkg::ST_SQRT:
            begin
                r_next = sq_r;
                q_next = shl2;
                t_next = sq_t;
                if (last_step)
                begin
                    r_next     = '0;
                    d_next     = DW'(sd3);
                    q_next     = DW'(var_reg) << (DW - tsat_pkg::VAR_W);
                    step_next  = STW'(tsat_pkg::VAR_W - 1);
                    state_next = tsat_pkg::ST_TMUL;
                end
            end
            tsat_pkg::ST_TMUL:
            begin
                r_next = mul_r;
                q_next = shl1;
                if (last_step)
                begin
                    r_next     = '0;
                    q_next     = DW'(mul_r[tsat_pkg::PROD_W-1:0]) << (DW - tsat_pkg::PROD_W);
                    d_next     = DW'(tdiv_den);
                    step_next  = STW'(tsat_pkg::PROD_W - 1);
                    state_next = tsat_pkg::ST_TDIV;
                end
            end
            tsat_pkg::ST_TDIV:
            begin
                r_next = div_r;
                q_next = div_q;
                if (last_step)
                begin
                    // mean + term stays inside Q12.8, no clamp needed
                    thr_next   = {{(tsat_pkg::THR_W - tsat_pkg::MEAN_W){mean_reg[tsat_pkg::MEAN_W-1]}},
                                  mean_reg} +
                                 {{(tsat_pkg::THR_W - tsat_pkg::TERM_W){1'b0}}, term};
                    state_next = tsat_pkg::ST_DONE;
                end
            end
            tsat_pkg::ST_DONE:
            begin
                if (take)
                begin
                    clear      = 1'b1;
                    state_next = tsat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsat_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsat_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        t_reg    <= t_next;
        mean_reg <= mean_next;
        var_reg  <= var_next;
        thr_reg  <= thr_next;
        few_reg  <= few_next;
    end

    assign busy = (state_reg != tsat_pkg::ST_IDLE);
    assign done = (state_reg == tsat_pkg::ST_DONE);

    assign result.threshold = thr_reg;
    assign result.mean      = mean_reg;
    assign result.variance  = var_reg;
    assign result.too_few   = few_reg;

endmodule

// File: rtl/core/three_sigma_activity_threshold_core.sv
// Top level of the three-sigma activity threshold core.
//
// Takes signed Q8.8 samples one per cycle on the smp channel; an item with
// last set closes the row. Only a row's last sample starts a stall. Up to
// MAX_SAMPLES samples of a row are counted; later ones in the same row are
// dropped, but their last flag still closes the row. On the last sample the
// core stalls the smp channel while one shared adder/subtractor, run by a
// small sequencer, works through: mean (restoring divide, SW steps), n*Q
// (shift-add, CW steps), S*S (SW steps), the numerator subtract (1), n*(n-1)
// (CW steps), variance divide (DW steps), sqrt of var*256 (16 steps), 3*sd*var
// (24 steps) and the divide by 256+var (42 steps), plus a load and a result
// state. Here CW = clog2(MAX_SAMPLES+1), SW = 16+clog2(MAX_SAMPLES),
// DW = max(CW+QW, 2*SW, 42) with QW = 31+clog2(MAX_SAMPLES). A row of one
// sample ends after the mean. A result sits in an output register, so the next
// row's samples are taken while res_stall holds it. Rows with fewer than two
// samples flag too_few with zero variance and threshold. Variance saturates to
// 2^24-1.
module three_sigma_activity_threshold_core #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                smp_valid,
    output logic                smp_stall,
    input  tsat_pkg::in_item_t  smp_data,
    output logic                res_valid,
    input  logic                res_stall,
    output tsat_pkg::out_item_t res_data
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = tsat_pkg::SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int QW = 2 * tsat_pkg::SAMPLE_W - 1 + $clog2(MAX_SAMPLES);

    logic                 smp_take;
    logic                 seq_busy, seq_done, seq_clear, seq_take;
    logic [CW-1:0]        acc_count;
    logic signed [SW-1:0] acc_sum;
    logic [QW-1:0]        acc_sqsum;
    tsat_pkg::out_item_t  seq_result;

    logic                 res_valid_reg, res_valid_next;
    tsat_pkg::out_item_t  res_data_reg;

    // samples are taken only while the sequencer is idle
    assign smp_stall = seq_busy;
    assign smp_take  = smp_valid && !seq_busy;

    tsat_accum #(.MAX_SAMPLES(MAX_SAMPLES)) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc_en (smp_take),
        .clear  (seq_clear),
        .item   (smp_data),
        .count  (acc_count),
        .sum    (acc_sum),
        .sqsum  (acc_sqsum)
    );

    tsat_seq #(.MAX_SAMPLES(MAX_SAMPLES)) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (smp_take && smp_data.last),
        .take   (seq_take),
        .count  (acc_count),
        .sum    (acc_sum),
        .sqsum  (acc_sqsum),
        .busy   (seq_busy),
        .done   (seq_done),
        .clear  (seq_clear),
        .result (seq_result)
    );

    // output register: loads when empty or being drained this cycle
    assign seq_take = seq_done && (!res_valid_reg || !res_stall);

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (seq_take)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_take)
        begin
            res_data_reg <= seq_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// File: rtl/core/tsat_checker.sv
// Port-level checks for the threshold core, bound to the top level.
module tsat_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                smp_valid,
    input logic                smp_stall,
    input tsat_pkg::in_item_t  smp_data,
    input logic                res_valid,
    input logic                res_stall,
    input tsat_pkg::out_item_t res_data
);

    // closing a row starts the computation, so the next cycle is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (smp_valid && !smp_stall && smp_data.last) |=> smp_stall)
        else $error("row close did not stall the sample channel");

    // a held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
        else $error("stalled result changed");

    // short rows report no spread
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.too_few) |->
        (res_data.variance == '0 && res_data.threshold == '0))
        else $error("too_few result with nonzero variance or threshold");

    // zero variance means zero spread term: threshold equals mean
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.too_few && res_data.variance == '0) |->
        (res_data.threshold ==
         {{(tsat_pkg::THR_W - tsat_pkg::MEAN_W){res_data.mean[tsat_pkg::MEAN_W-1]}},
          res_data.mean}))
        else $error("flat row threshold differs from mean");

endmodule

bind three_sigma_activity_threshold_core tsat_checker u_tsat_checker (.*);
